// ===== sv/per_queue_container_write_organizer_macros.svh =====
// Assertion macros for the per-queue container write organizer.
// Expects signals clk and arst_n in the module that uses them.
`ifndef PER_QUEUE_CONTAINER_WRITE_ORGANIZER_MACROS_SVH
`define PER_QUEUE_CONTAINER_WRITE_ORGANIZER_MACROS_SVH
// Same-cycle implication.
`define PQCWO_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pqcwo assertion failed");
// Next-cycle implication.
`define PQCWO_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pqcwo assertion failed");
`endif

// ===== sv/pqcwo_pkg.sv =====
// Package of the per-queue container write organizer: widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pqcwo_pkg;
	localparam int QUEUE_BITS = 11;
	localparam int OFFSET_BITS = 20;
	localparam int CONT_BITS = 16;
	localparam int OFF_W = OFFSET_BITS + 1;
	localparam int ADDR_W = CONT_BITS + OFFSET_BITS;
	localparam logic [OFF_W-1:0] CBYTES = OFF_W'(1) << OFFSET_BITS;

	localparam logic [1:0] ACT_QUEUE = 2'd0;
	localparam logic [1:0] ACT_REQ = 2'd1;
	localparam logic [1:0] ACT_SIZE = 2'd2;
	localparam logic [1:0] ACT_CONT = 2'd3;

	localparam logic [2:0] KIND_NOTICE = 3'd0;
	localparam logic [2:0] KIND_NACK = 3'd1;
	localparam logic [2:0] KIND_XFER = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_REFUSE = 3'd4;

	localparam logic [2:0] NOTE_CLOSE = 3'd1;
	localparam logic [2:0] NOTE_WRITE = 3'd2;
	localparam logic [2:0] NOTE_OPEN = 3'd3;
	localparam logic [2:0] NOTE_ACK = 3'd4;
	localparam logic [2:0] NACK_NONE = 3'd0;
	localparam logic [2:0] NACK_INVALID = 3'd1;
	localparam logic [2:0] NACK_BADPW = 3'd2;
	localparam logic [2:0] WR_GO = 3'd0;
	localparam logic [2:0] WR_DROP = 3'd1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'd1, ST_NEED_CONT = 4'd2, ST_REPLY = 4'd3, ST_DROPPED = 4'd5,
		ST_END = 4'd6, ST_LAST = 4'd8, ST_TRAIL = 4'd9
	} stage_t;

	typedef enum logic [1:0] {CS_CLEAR, CS_IDLE, CS_EXEC, CS_EMIT} ctl_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic exec_none;
		logic emit_last;
	} status_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [QUEUE_BITS-1:0] queue;
		logic [2:0] code;
		logic [31:0] ip;
		logic [23:0] seq;
		logic [CONT_BITS-1:0] cont;
		logic [OFF_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		logic treq;
		logic skip;
		logic lastt;
	} res_t;
endpackage
`default_nettype wire

// ===== sv/pqcwo_ctrl.sv =====
// Controller of the per-queue container write organizer: clear, accept, exec, emit.
// Depends on pqcwo_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "per_queue_container_write_organizer_macros.svh"
module pqcwo_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire pqcwo_pkg::status_t status,
	output pqcwo_pkg::cmd_t cmd,
	output logic busy
);
	pqcwo_pkg::ctl_state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pqcwo_pkg::CS_CLEAR;
		else state_q <= state_d;
	end

	// advance sequence and drive commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			pqcwo_pkg::CS_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) state_d = pqcwo_pkg::CS_IDLE;
			end
			pqcwo_pkg::CS_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d = pqcwo_pkg::CS_EXEC;
				end
			end
			pqcwo_pkg::CS_EXEC: begin
				cmd.exec = 1'b1;
				state_d = status.exec_none ? pqcwo_pkg::CS_IDLE : pqcwo_pkg::CS_EMIT;
			end
			pqcwo_pkg::CS_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_last) state_d = pqcwo_pkg::CS_IDLE;
			end
			default: state_d = pqcwo_pkg::CS_CLEAR;
		endcase
	end

	`PQCWO_ASSERT_NXT(a_accept_exec, start && !busy, cmd.exec)
	`PQCWO_ASSERT_NXT(a_exec_once, cmd.exec, !cmd.exec)
	`PQCWO_ASSERT_NXT(a_emit_end, cmd.emit && status.emit_last, !cmd.emit && !busy)
endmodule
`default_nettype wire

// ===== sv/pqcwo_dp.sv =====
// Datapath of the per-queue container write organizer: queue table memories,
// stage register, result buffer. Depends on pqcwo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pqcwo_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire pqcwo_pkg::cmd_t cmd,
	output pqcwo_pkg::status_t status,
	input wire logic [1:0] action,
	input wire logic [10:0] queue_index,
	input wire logic add_queue,
	input wire logic [31:0] password,
	input wire logic first_part,
	input wire logic last_part,
	input wire logic [31:0] client_ip,
	input wire logic [23:0] sequence_number,
	input wire logic solicited,
	input wire logic [63:0] value,
	output pqcwo_pkg::res_t res,
	output logic res_last
);
	localparam int QN = 1 << pqcwo_pkg::QUEUE_BITS;
	localparam int CB = pqcwo_pkg::CONT_BITS;
	localparam int OW = pqcwo_pkg::OFF_W;
	localparam int QB = pqcwo_pkg::QUEUE_BITS;

	typedef struct packed {
		logic [31:0] pw;
		logic [31:0] ip;
		logic [CB-1:0] cont;
		logic [OW-1:0] off;
	} data_t;

	typedef struct packed {
		logic [QB-1:0] queue;
		logic [31:0] pw;
		logic [31:0] ip;
		logic [23:0] seq;
		logic first;
		logic last;
		logic sol;
	} req_t;

	typedef struct packed {
		logic inprog;
		logic hs;
		logic valid;
		data_t d;
	} work_t;

	// table memories
	logic [2:0] flag_mem [QN];
	data_t data_mem [QN];
	logic [2:0] flag_rd_q;
	data_t data_rd_q;

	// latched item
	logic [1:0] act_q;
	logic [QB-1:0] queue_q;
	logic add_q, first_q, last_q, sol_q;
	logic [31:0] pw_q, ip_q;
	logic [23:0] seq_q;
	logic [63:0] val_q;

	// file state
	pqcwo_pkg::stage_t stage_q, st_d;
	logic [63:0] sl_q, sl_d;
	logic [OW-1:0] max_q, max_d;
	req_t pend_q, pr;
	work_t work_q, w;

	// result buffer
	pqcwo_pkg::res_t res_q [4];
	pqcwo_pkg::res_t res_d [4];
	logic [2:0] cnt_q, n;
	logic [1:0] idx_q;
	logic [QB-1:0] clr_q;

	// memory write controls
	logic fl_we, dt_we;
	logic [QB-1:0] wa;
	logic [2:0] fl_wd;
	data_t dt_wd;

	logic ok, do_drop, do_store;
	logic [2:0] reason;
	logic [CB-1:0] cin;
	logic [63:0] sl_sub;
	logic [OW-1:0] sum_off;

	function automatic logic [pqcwo_pkg::ADDR_W-1:0] addr_of(input logic [CB-1:0] c,
			input logic [OW-1:0] o);
		addr_of = {c, {pqcwo_pkg::OFFSET_BITS{1'b0}}} | pqcwo_pkg::ADDR_W'(o);
	endfunction

	function automatic pqcwo_pkg::res_t r_notice(input logic [QB-1:0] q,
			input logic [2:0] c, input logic [31:0] ip);
		r_notice = '0;
		r_notice.kind = pqcwo_pkg::KIND_NOTICE;
		r_notice.queue = q;
		r_notice.code = c;
		r_notice.ip = ip;
	endfunction

	function automatic pqcwo_pkg::res_t r_write(input logic [QB-1:0] q,
			input logic [2:0] c, input logic [OW-1:0] sz,
			input logic [pqcwo_pkg::ADDR_W-1:0] a);
		r_write = '0;
		r_write.kind = pqcwo_pkg::KIND_WRITE;
		r_write.queue = q;
		r_write.code = c;
		r_write.size = sz;
		r_write.addr = a;
	endfunction

	function automatic pqcwo_pkg::res_t r_xfer(input logic [QB-1:0] q, input logic tr,
			input logic [CB-1:0] c, input logic [OW-1:0] sz, input logic sk,
			input logic lt);
		r_xfer = '0;
		r_xfer.kind = pqcwo_pkg::KIND_XFER;
		r_xfer.queue = q;
		r_xfer.treq = tr;
		r_xfer.cont = c;
		r_xfer.size = sz;
		r_xfer.skip = sk;
		r_xfer.lastt = lt;
	endfunction

	function automatic pqcwo_pkg::res_t r_nack(input logic [QB-1:0] q,
			input logic [2:0] c, input logic [31:0] ip, input logic [23:0] sq);
		r_nack = '0;
		r_nack.kind = pqcwo_pkg::KIND_NACK;
		r_nack.queue = q;
		r_nack.code = c;
		r_nack.ip = ip;
		r_nack.seq = sq;
	endfunction

	// read table and latch item on accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			flag_rd_q <= flag_mem[queue_index];
			data_rd_q <= data_mem[queue_index];
			act_q <= action;
			queue_q <= queue_index;
			add_q <= add_queue;
			pw_q <= password;
			first_q <= first_part;
			last_q <= last_part;
			ip_q <= client_ip;
			seq_q <= sequence_number;
			sol_q <= solicited;
			val_q <= value;
		end
	end

	// write table: clearing pass, then exec write-back
	always_ff @(posedge clk) begin
		if (cmd.clear) flag_mem[clr_q] <= 3'b000;
		else if (cmd.exec && fl_we) flag_mem[wa] <= fl_wd;
		if (cmd.exec && dt_we) data_mem[wa] <= dt_wd;
	end

	// hold result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < 4; i++) res_q[i] <= res_d[i];
		end
	end

	// update file state and buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= pqcwo_pkg::ST_IDLE;
			sl_q <= '0;
			max_q <= '0;
			pend_q <= '0;
			work_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.exec) begin
				stage_q <= st_d;
				sl_q <= sl_d;
				max_q <= max_d;
				pend_q <= pr;
				work_q <= w;
				cnt_q <= n;
				idx_q <= '0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// work out results and next state for the latched item
	always_comb begin
		pr = pend_q;
		w = work_q;
		st_d = stage_q;
		sl_d = sl_q;
		max_d = max_q;
		for (int i = 0; i < 4; i++) res_d[i] = '0;
		n = '0;
		ok = 1'b0;
		do_drop = 1'b0;
		do_store = 1'b0;
		reason = pqcwo_pkg::NACK_NONE;
		fl_we = 1'b0;
		dt_we = 1'b0;
		wa = queue_q;
		fl_wd = '0;
		dt_wd = '0;
		cin = val_q[CB-1:0];
		sl_sub = '0;
		sum_off = '0;
		case (stage_q)
			pqcwo_pkg::ST_IDLE: begin
				if (act_q == pqcwo_pkg::ACT_QUEUE) begin
					ok = 1'b1;
					fl_we = 1'b1;
					if (add_q) begin
						res_d[n[1:0]] = r_notice(queue_q, pqcwo_pkg::NOTE_OPEN, '0);
						n = n + 3'd1;
						fl_wd = 3'b001;
						dt_we = 1'b1;
						dt_wd.pw = pw_q;
					end else begin
						res_d[n[1:0]] = r_notice(queue_q, pqcwo_pkg::NOTE_CLOSE, '0);
						n = n + 3'd1;
					end
				end else if (act_q == pqcwo_pkg::ACT_REQ) begin
					ok = 1'b1;
					pr.queue = queue_q;
					pr.pw = pw_q;
					pr.first = first_q;
					pr.last = last_q;
					pr.ip = ip_q;
					pr.seq = seq_q;
					pr.sol = sol_q;
					w.valid = flag_rd_q[0];
					w.hs = flag_rd_q[1];
					w.inprog = flag_rd_q[2];
					w.d = data_rd_q;
					if (!w.valid) begin
						do_drop = 1'b1;
						reason = pqcwo_pkg::NACK_INVALID;
					end else if (pr.first) begin
						if (w.d.pw != pr.pw || w.inprog) begin
							do_drop = 1'b1;
							reason = pqcwo_pkg::NACK_BADPW;
						end else begin
							st_d = pqcwo_pkg::ST_NEED_CONT;
						end
					end else if (w.d.ip != pr.ip || !w.inprog) begin
						do_drop = 1'b1;
					end else if (w.hs) begin
						max_d = pqcwo_pkg::CBYTES - w.d.off;
						res_d[n[1:0]] = r_write(pr.queue, pqcwo_pkg::WR_GO, max_d,
							addr_of(w.d.cont, w.d.off));
						n = n + 3'd1;
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b0, '0, '0, 1'b0, 1'b0);
						n = n + 3'd1;
						st_d = pr.last ? pqcwo_pkg::ST_END : pqcwo_pkg::ST_REPLY;
					end else begin
						st_d = pqcwo_pkg::ST_NEED_CONT;
					end
				end
			end
			pqcwo_pkg::ST_NEED_CONT: begin
				if (act_q == pqcwo_pkg::ACT_CONT) begin
					ok = 1'b1;
					res_d[n[1:0]] = r_notice(pr.queue, pqcwo_pkg::NOTE_WRITE, '0);
					n = n + 3'd1;
					if (pr.first) w.d.ip = pr.ip;
					w.d.cont = cin;
					w.d.off = '0;
					w.hs = 1'b1;
					w.inprog = 1'b1;
					max_d = pqcwo_pkg::CBYTES;
					res_d[n[1:0]] = r_write(pr.queue, pqcwo_pkg::WR_GO, pqcwo_pkg::CBYTES,
						addr_of(cin, '0));
					n = n + 3'd1;
					res_d[n[1:0]] = r_xfer(pr.queue, 1'b0, '0, '0, 1'b0, 1'b0);
					n = n + 3'd1;
					st_d = pr.last ? pqcwo_pkg::ST_END : pqcwo_pkg::ST_REPLY;
				end
			end
			pqcwo_pkg::ST_DROPPED: begin
				if (act_q == pqcwo_pkg::ACT_SIZE) begin
					ok = 1'b1;
					sl_d = val_q;
					st_d = pqcwo_pkg::ST_IDLE;
				end
			end
			pqcwo_pkg::ST_REPLY: begin
				if (act_q == pqcwo_pkg::ACT_SIZE) begin
					ok = 1'b1;
					sl_d = val_q;
					do_store = 1'b1;
					if (64'(max_q) > val_q) begin
						w.d.off = w.d.off + val_q[OW-1:0];
						st_d = pqcwo_pkg::ST_IDLE;
					end else begin
						w.hs = 1'b0;
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b1, w.d.cont, pqcwo_pkg::CBYTES,
							1'b1, 1'b0);
						n = n + 3'd1;
						if (64'(max_q) == val_q) begin
							st_d = pqcwo_pkg::ST_IDLE;
						end else begin
							sl_d = val_q - 64'(max_q);
							st_d = pqcwo_pkg::ST_TRAIL;
						end
					end
				end
			end
			pqcwo_pkg::ST_TRAIL: begin
				if (act_q == pqcwo_pkg::ACT_CONT) begin
					ok = 1'b1;
					do_store = 1'b1;
					res_d[n[1:0]] = r_notice(pr.queue, pqcwo_pkg::NOTE_WRITE, '0);
					n = n + 3'd1;
					res_d[n[1:0]] = r_write(pr.queue, pqcwo_pkg::WR_GO, pqcwo_pkg::CBYTES,
						addr_of(cin, '0));
					n = n + 3'd1;
					if (64'(pqcwo_pkg::CBYTES) > sl_q) begin
						w.hs = 1'b1;
						w.d.off = sl_q[OW-1:0];
						w.d.cont = cin;
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b0, '0, '0, 1'b0, 1'b0);
						n = n + 3'd1;
						st_d = pqcwo_pkg::ST_IDLE;
					end else begin
						w.hs = 1'b0;
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b1, cin, pqcwo_pkg::CBYTES,
							1'b0, 1'b0);
						n = n + 3'd1;
						sl_sub = sl_q - 64'(pqcwo_pkg::CBYTES);
						sl_d = sl_sub;
						if (sl_sub == '0) st_d = pqcwo_pkg::ST_IDLE;
					end
				end
			end
			pqcwo_pkg::ST_END: begin
				if (act_q == pqcwo_pkg::ACT_SIZE) begin
					ok = 1'b1;
					sl_d = val_q;
					w.inprog = 1'b0;
					w.hs = 1'b0;
					do_store = 1'b1;
					if (64'(max_q) >= val_q) begin
						sum_off = w.d.off + val_q[OW-1:0];
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b1, w.d.cont, sum_off, 1'b1, 1'b1);
						n = n + 3'd1;
						if (pr.sol) begin
							res_d[n[1:0]] = r_notice(pr.queue, pqcwo_pkg::NOTE_ACK, pr.ip);
							n = n + 3'd1;
						end
						st_d = pqcwo_pkg::ST_IDLE;
					end else begin
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b1, w.d.cont, pqcwo_pkg::CBYTES,
							1'b1, 1'b0);
						n = n + 3'd1;
						sl_d = val_q - 64'(max_q);
						st_d = pqcwo_pkg::ST_LAST;
					end
				end
			end
			pqcwo_pkg::ST_LAST: begin
				if (act_q == pqcwo_pkg::ACT_CONT) begin
					ok = 1'b1;
					w.hs = 1'b0;
					do_store = 1'b1;
					res_d[n[1:0]] = r_notice(pr.queue, pqcwo_pkg::NOTE_WRITE, '0);
					n = n + 3'd1;
					if (64'(pqcwo_pkg::CBYTES) > sl_q) begin
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b1, cin, sl_q[OW-1:0], 1'b0, 1'b1);
						n = n + 3'd1;
						res_d[n[1:0]] = r_write(pr.queue, pqcwo_pkg::WR_GO,
							pqcwo_pkg::CBYTES, addr_of(cin, '0));
						n = n + 3'd1;
						if (pr.sol) begin
							res_d[n[1:0]] = r_notice(pr.queue, pqcwo_pkg::NOTE_ACK, pr.ip);
							n = n + 3'd1;
						end
						st_d = pqcwo_pkg::ST_IDLE;
					end else begin
						sl_sub = sl_q - 64'(pqcwo_pkg::CBYTES);
						res_d[n[1:0]] = r_write(pr.queue, pqcwo_pkg::WR_GO,
							pqcwo_pkg::CBYTES, addr_of(cin, '0));
						n = n + 3'd1;
						res_d[n[1:0]] = r_xfer(pr.queue, 1'b1, cin, pqcwo_pkg::CBYTES, 1'b0,
							sl_sub == '0);
						n = n + 3'd1;
						sl_d = sl_sub;
						if (sl_sub == '0) begin
							if (pr.sol) begin
								res_d[n[1:0]] = r_notice(pr.queue, pqcwo_pkg::NOTE_ACK, pr.ip);
								n = n + 3'd1;
							end
							st_d = pqcwo_pkg::ST_IDLE;
						end
					end
				end
			end
			default: ok = 1'b0;
		endcase
		// drop a bad packet: drop write, plain xfer, nack if solicited with reason
		if (do_drop) begin
			res_d[n[1:0]] = r_write(pr.queue, pqcwo_pkg::WR_DROP, '0, '0);
			n = n + 3'd1;
			res_d[n[1:0]] = r_xfer(pr.queue, 1'b0, '0, '0, 1'b0, 1'b0);
			n = n + 3'd1;
			if (reason != pqcwo_pkg::NACK_NONE && pr.sol) begin
				res_d[n[1:0]] = r_nack(pr.queue, reason, pr.ip, pr.seq);
				n = n + 3'd1;
			end
			st_d = pqcwo_pkg::ST_DROPPED;
		end
		// write back the working entry
		if (do_store) begin
			fl_we = 1'b1;
			dt_we = 1'b1;
			wa = pr.queue;
			fl_wd = {w.inprog, w.hs, w.valid};
			dt_wd = w.d;
		end
		// refuse an item the stage cannot take
		if (!ok) begin
			res_d[0] = '0;
			res_d[0].kind = pqcwo_pkg::KIND_REFUSE;
			res_d[0].queue = queue_q;
			n = 3'd1;
		end
	end

	assign status.clear_last = &clr_q;
	assign status.exec_none = (n == '0);
	assign status.emit_last = (3'({1'b0, idx_q}) + 3'd1 == cnt_q);
	assign res = res_q[idx_q];
	assign res_last = status.emit_last;
endmodule
`default_nettype wire

// ===== sv/per_queue_container_write_organizer.sv =====
// Top level of the per-queue container write organizer.
// Depends on pqcwo_pkg, pqcwo_ctrl and pqcwo_dp.
//
//  channel   handshake           payload
//  item      start / busy        action .. value
//  result    strobe (1 cycle)    kind .. last_of_run
//
// Per item: the queue table is read and the item latched on accept, then the
// results are worked out and the entry written back, then the results (0 to 4)
// are presented. After reset all 2048 flag entries are cleared, one a cycle,
// with busy high. Results cannot be stalled; strobe marks each for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module per_queue_container_write_organizer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] action,
	input wire logic [10:0] queue_index,
	input wire logic add_queue,
	input wire logic [31:0] password,
	input wire logic first_part,
	input wire logic last_part,
	input wire logic [31:0] client_ip,
	input wire logic [23:0] sequence_number,
	input wire logic solicited,
	input wire logic [63:0] value,
	output logic strobe,
	output logic [2:0] kind,
	output logic [10:0] result_queue,
	output logic [2:0] code,
	output logic [31:0] ip_out,
	output logic [23:0] seq_out,
	output logic [15:0] container_out,
	output logic [20:0] size_out,
	output logic [35:0] start_addr,
	output logic transfer_request,
	output logic skip_flag,
	output logic last_transfer,
	output logic last_of_run
);
	pqcwo_pkg::cmd_t cmd;
	pqcwo_pkg::status_t status;
	pqcwo_pkg::res_t res;

	pqcwo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status), .cmd(cmd),
		.busy(busy)
	);

	pqcwo_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .action(action),
		.queue_index(queue_index), .add_queue(add_queue), .password(password),
		.first_part(first_part), .last_part(last_part), .client_ip(client_ip),
		.sequence_number(sequence_number), .solicited(solicited), .value(value),
		.res(res), .res_last(last_of_run)
	);

	// present the current result beat
	assign strobe = cmd.emit;
	assign kind = res.kind;
	assign result_queue = res.queue;
	assign code = res.code;
	assign ip_out = res.ip;
	assign seq_out = res.seq;
	assign container_out = res.cont;
	assign size_out = res.size;
	assign start_addr = res.addr;
	assign transfer_request = res.treq;
	assign skip_flag = res.skip;
	assign last_transfer = res.lastt;
endmodule
`default_nettype wire
